// ===== hw/rtl/msc_pkg.sv =====
// Package for the MIDI effect settings controller.
// Holds the item structs, the configuration struct, action codes and defaults.
// No dependencies.
package msc_pkg;

  // Default values of the top-level parameters
  localparam int NUM_EFFECTS_DEF      = 16;
  localparam int SAVE_DELAY_TICKS_DEF = 200;
  localparam int DISPLAY_TICKS_DEF    = 30;

  // Field widths
  localparam int EFF_W    = 4;
  localparam int BRIGHT_W = 8;
  localparam int OFS_W    = 8;
  localparam int DELAY_W  = 8;
  localparam int DISP_W   = 5;
  localparam int LIT_W    = 5;
  localparam int SAVED_W  = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [1:0] REG_CONTROL_CH = 2'd0;
  localparam logic [1:0] REG_CHORD_CH   = 2'd1;
  localparam logic [1:0] REG_BASS_CH    = 2'd2;
  localparam logic [1:0] REG_BRIGHT_CC  = 2'd3;

  // Register reset values
  localparam logic [3:0] CONTROL_CH_RST = 4'd0;
  localparam logic [3:0] CHORD_CH_RST   = 4'd4;
  localparam logic [3:0] BASS_CH_RST    = 4'd5;
  localparam logic [6:0] BRIGHT_CC_RST  = 7'd91;

  // Action codes
  localparam logic [2:0] ACT_RESTORE  = 3'd0;
  localparam logic [2:0] ACT_NOTE_ON  = 3'd1;
  localparam logic [2:0] ACT_CTRL     = 3'd2;
  localparam logic [2:0] ACT_PROGRAM  = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;

  // Clamp limits and constants
  localparam logic signed [SAVED_W-1:0] BRIGHT_MIN = 16'sd12;
  localparam logic signed [SAVED_W-1:0] BRIGHT_MAX = 16'sd255;
  localparam logic signed [SAVED_W-1:0] OFS_MIN    = -16'sd63;
  localparam logic signed [SAVED_W-1:0] OFS_MAX    = 16'sd63;
  localparam logic [OFS_W-1:0]          KEY_CENTER = 8'd64;
  localparam logic [BRIGHT_W-1:0]       BRIGHT_RST = 8'd255;

  typedef struct packed {
    logic [2:0]                 action;
    logic [3:0]                 channel;
    logic [6:0]                 key;
    logic [6:0]                 value;
    logic signed [SAVED_W-1:0]  saved_effect;
    logic signed [SAVED_W-1:0]  saved_brightness;
    logic signed [SAVED_W-1:0]  saved_chord_shift;
    logic signed [SAVED_W-1:0]  saved_bass_shift;
  } in_item_t;

  typedef struct packed {
    logic [EFF_W-1:0]         effect_index;
    logic [BRIGHT_W-1:0]      brightness_level;
    logic signed [OFS_W-1:0]  chord_shift;
    logic signed [OFS_W-1:0]  bass_shift;
    logic                     settings_changed;
    logic                     commit_strobe;
    logic                     show_index;
    logic [LIT_W-1:0]         lit_count;
  } out_item_t;

  typedef struct packed {
    logic [3:0] control_channel;
    logic [3:0] chord_channel;
    logic [3:0] bass_channel;
    logic [6:0] brightness_controller;
  } cfg_t;

endpackage

// ===== hw/rtl/msc_cfg.sv =====
// Configuration register file on an APB-style port.
// Depends on msc_pkg for the register indexes, reset values and cfg_t.
module msc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [msc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [msc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output msc_pkg::cfg_t                   cfg
);
  import msc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CONTROL_CH: cfg_nxt.control_channel       = pwdata[3:0];
        REG_CHORD_CH:   cfg_nxt.chord_channel         = pwdata[3:0];
        REG_BASS_CH:    cfg_nxt.bass_channel          = pwdata[3:0];
        REG_BRIGHT_CC:  cfg_nxt.brightness_controller = pwdata[6:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_channel       <= CONTROL_CH_RST;
      cfg_r.chord_channel         <= CHORD_CH_RST;
      cfg_r.bass_channel          <= BASS_CH_RST;
      cfg_r.brightness_controller <= BRIGHT_CC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_CONTROL_CH: prdata = CFG_DATA_W'(cfg_r.control_channel);
      REG_CHORD_CH:   prdata = CFG_DATA_W'(cfg_r.chord_channel);
      REG_BASS_CH:    prdata = CFG_DATA_W'(cfg_r.bass_channel);
      REG_BRIGHT_CC:  prdata = CFG_DATA_W'(cfg_r.brightness_controller);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/msc_core.sv =====
// Settings state and event logic: computes one result per item from the
// registered input item and updates the settings and timers on each step.
// Depends on msc_pkg for item types, action codes and limits.
module msc_core #(
  parameter int NUM_EFFECTS      = msc_pkg::NUM_EFFECTS_DEF,
  parameter int SAVE_DELAY_TICKS = msc_pkg::SAVE_DELAY_TICKS_DEF,
  parameter int DISPLAY_TICKS    = msc_pkg::DISPLAY_TICKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  msc_pkg::in_item_t   item,
  input  msc_pkg::cfg_t       cfg,
  output msc_pkg::out_item_t  result
);
  import msc_pkg::*;

  localparam logic [EFF_W:0]            EFF_LIMIT  = (EFF_W+1)'(NUM_EFFECTS);
  localparam logic signed [SAVED_W-1:0] EFF_MAX    = SAVED_W'(NUM_EFFECTS - 1);
  localparam logic [DELAY_W-1:0]        DELAY_LOAD = DELAY_W'(SAVE_DELAY_TICKS);
  localparam logic [DISP_W-1:0]         DISP_LOAD  = DISP_W'(DISPLAY_TICKS);

  logic [EFF_W-1:0]        effect_r,  effect_nxt;
  logic [BRIGHT_W-1:0]     bright_r,  bright_nxt;
  logic [OFS_W-1:0]        chord_r,   chord_nxt;
  logic [OFS_W-1:0]        bass_r,    bass_nxt;
  logic [DELAY_W-1:0]      delay_r,   delay_nxt;
  logic [DISP_W-1:0]       disp_r,    disp_nxt;

  logic [EFF_W:0]          eff_inc;
  logic [OFS_W-1:0]        key_ofs;
  logic                    changed, strobe, show;
  logic [LIT_W-1:0]        lit;
  logic signed [SAVED_W-1:0] eff_cl, bright_cl, chord_cl, bass_cl;

  assign eff_inc = {1'b0, effect_r} + (EFF_W+1)'(1);
  assign key_ofs = KEY_CENTER - {1'b0, item.key};

  // restore clamps
  always_comb begin
    eff_cl = item.saved_effect;
    if (item.saved_effect < 0)       eff_cl = '0;
    if (item.saved_effect > EFF_MAX) eff_cl = EFF_MAX;
    bright_cl = item.saved_brightness;
    if (item.saved_brightness < BRIGHT_MIN) bright_cl = BRIGHT_MIN;
    if (item.saved_brightness > BRIGHT_MAX) bright_cl = BRIGHT_MAX;
    chord_cl = item.saved_chord_shift;
    if (item.saved_chord_shift < OFS_MIN) chord_cl = OFS_MIN;
    if (item.saved_chord_shift > OFS_MAX) chord_cl = OFS_MAX;
    bass_cl = item.saved_bass_shift;
    if (item.saved_bass_shift < OFS_MIN) bass_cl = OFS_MIN;
    if (item.saved_bass_shift > OFS_MAX) bass_cl = OFS_MAX;
  end

  // event decode and next settings
  always_comb begin
    effect_nxt = effect_r;
    bright_nxt = bright_r;
    chord_nxt  = chord_r;
    bass_nxt   = bass_r;
    delay_nxt  = delay_r;
    disp_nxt   = disp_r;
    changed    = 1'b0;
    strobe     = 1'b0;
    show       = 1'b0;
    lit        = '0;
    unique case (item.action)
      ACT_RESTORE: begin
        effect_nxt = eff_cl[EFF_W-1:0];
        bright_nxt = bright_cl[BRIGHT_W-1:0];
        chord_nxt  = chord_cl[OFS_W-1:0];
        bass_nxt   = bass_cl[OFS_W-1:0];
      end
      ACT_NOTE_ON: begin
        if (item.channel == cfg.control_channel) begin
          disp_nxt   = DISP_LOAD;
          delay_nxt  = DELAY_LOAD;
          changed    = 1'b1;
          effect_nxt = (eff_inc >= EFF_LIMIT) ? '0 : eff_inc[EFF_W-1:0];
        end
        if (item.channel == cfg.chord_channel) begin
          changed   = 1'b1;
          chord_nxt = key_ofs;
        end
        if (item.channel == cfg.bass_channel) begin
          changed  = 1'b1;
          bass_nxt = key_ofs;
        end
      end
      ACT_CTRL: begin
        // twice a 7-bit value never exceeds 254
        if (item.key == cfg.brightness_controller) begin
          delay_nxt  = DELAY_LOAD;
          bright_nxt = {item.value, 1'b0};
        end
      end
      ACT_PROGRAM: begin
        if (item.channel == cfg.control_channel &&
            {1'b0, item.value} < 8'(EFF_LIMIT)) begin
          changed    = 1'b1;
          effect_nxt = item.value[EFF_W-1:0];
        end
      end
      ACT_TICK: begin
        if (delay_r != '0) begin
          delay_nxt = delay_r - DELAY_W'(1);
          strobe    = (delay_r == DELAY_W'(2));
        end
        if (disp_r != '0) begin
          disp_nxt = disp_r - DISP_W'(1);
          show     = 1'b1;
          lit      = LIT_W'(eff_inc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r <= '0;
      bright_r <= BRIGHT_RST;
      chord_r  <= '0;
      bass_r   <= '0;
      delay_r  <= '0;
      disp_r   <= '0;
    end else if (step) begin
      effect_r <= effect_nxt;
      bright_r <= bright_nxt;
      chord_r  <= chord_nxt;
      bass_r   <= bass_nxt;
      delay_r  <= delay_nxt;
      disp_r   <= disp_nxt;
    end
  end

  // result reports settings after the event
  assign result.effect_index     = effect_nxt;
  assign result.brightness_level = bright_nxt;
  assign result.chord_shift      = chord_nxt;
  assign result.bass_shift       = bass_nxt;
  assign result.settings_changed = changed;
  assign result.commit_strobe    = strobe;
  assign result.show_index       = show;
  assign result.lit_count        = lit;

endmodule

// ===== hw/rtl/midi_effect_settings_control.sv =====
// MIDI effect settings controller, top level. The result of an accepted item
// passes through the input register, then the result register. Throughput: one
// item per cycle while the result is not stalled; the single-pass event logic sets
// that. A stalled result holds the input register.
// Reset (rst_n, synchronous): pipeline empty, settings and timers at their
// reset values, configuration registers at defaults. Depends on msc_pkg.
module midi_effect_settings_control #(
  parameter int NUM_EFFECTS      = msc_pkg::NUM_EFFECTS_DEF,
  parameter int SAVE_DELAY_TICKS = msc_pkg::SAVE_DELAY_TICKS_DEF,
  parameter int DISPLAY_TICKS    = msc_pkg::DISPLAY_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  msc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output msc_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [msc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [msc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import msc_pkg::*;

  cfg_t       cfg;
  in_item_t   s1_item_r;
  logic       s1_valid_r, s1_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  result;
  logic       out_valid_r, out_valid_nxt;
  logic       s1_adv;
  logic       in_acc;

  msc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msc_core #(
    .NUM_EFFECTS      (NUM_EFFECTS),
    .SAVE_DELAY_TICKS (SAVE_DELAY_TICKS),
    .DISPLAY_TICKS    (DISPLAY_TICKS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // pipeline flow: stage 1 moves on when the result register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r  <= in_data;
    if (s1_adv) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== dv/midi_settings_checker.sv =====
// Checker for the MIDI effect settings controller: tracks config writes, predicts
// each result from accepted items and compares the result channel field by field.
// Depends on msc_pkg.
module midi_settings_checker #(
  parameter int NUM_EFFECTS      = msc_pkg::NUM_EFFECTS_DEF,
  parameter int SAVE_DELAY_TICKS = msc_pkg::SAVE_DELAY_TICKS_DEF,
  parameter int DISPLAY_TICKS    = msc_pkg::DISPLAY_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  msc_pkg::in_item_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  msc_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [msc_pkg::CFG_DATA_W-1:0]  pwdata,
  input  logic                            pready,
  output int                              pending,
  output int                              fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import msc_pkg::*;

  // Mirror of the configuration registers
  logic [3:0] ctl_ch, chord_ch, bass_ch;
  logic [6:0] bright_cc;

  // Mirror of the settings and timers
  logic [EFF_W-1:0]    cur_effect;
  logic [BRIGHT_W-1:0] cur_brightness;
  logic [OFS_W-1:0]    cur_chord, cur_bass;
  logic [DELAY_W-1:0]  save_timer;
  logic [DISP_W-1:0]   display_timer;

  out_item_t predicted_settings_q[$];
  int        result_no;

  initial begin
    pending    = 0;
    fail_count = 0;
    result_no  = 0;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One event in, the settings snapshot it leaves behind out
  task automatic apply_midi_event(input in_item_t ev, output out_item_t res);
    int raw;
    res = '0;
    case (ev.action)
      ACT_RESTORE: begin
        cur_effect     = EFF_W'(clamp(int'($signed(ev.saved_effect)), 0, NUM_EFFECTS - 1));
        cur_brightness = BRIGHT_W'(clamp(int'($signed(ev.saved_brightness)),
                                         int'(BRIGHT_MIN), int'(BRIGHT_MAX)));
        cur_chord      = OFS_W'(clamp(int'($signed(ev.saved_chord_shift)),
                                      int'(OFS_MIN), int'(OFS_MAX)));
        cur_bass       = OFS_W'(clamp(int'($signed(ev.saved_bass_shift)),
                                      int'(OFS_MIN), int'(OFS_MAX)));
      end
      ACT_NOTE_ON: begin
        // control channel is handled first when channels coincide
        if (ev.channel == ctl_ch) begin
          display_timer        = DISP_W'(DISPLAY_TICKS);
          save_timer           = DELAY_W'(SAVE_DELAY_TICKS);
          res.settings_changed = 1'b1;
          cur_effect = (int'(cur_effect) + 1 >= NUM_EFFECTS) ? '0 : cur_effect + 1'b1;
        end
        if (ev.channel == chord_ch) begin
          res.settings_changed = 1'b1;
          cur_chord = OFS_W'(int'(KEY_CENTER) - int'(ev.key));
        end
        if (ev.channel == bass_ch) begin
          res.settings_changed = 1'b1;
          cur_bass = OFS_W'(int'(KEY_CENTER) - int'(ev.key));
        end
      end
      ACT_CTRL: begin
        if (ev.key == bright_cc) begin
          raw            = 2 * int'(ev.value);
          cur_brightness = (raw > 255) ? 8'd255 : BRIGHT_W'(raw);
          save_timer     = DELAY_W'(SAVE_DELAY_TICKS);
        end
      end
      ACT_PROGRAM: begin
        if (ev.channel == ctl_ch && int'(ev.value) < NUM_EFFECTS) begin
          res.settings_changed = 1'b1;
          cur_effect = EFF_W'(ev.value);
        end
      end
      ACT_TICK: begin
        if (save_timer != 0) begin
          save_timer--;
          if (save_timer == 1) res.commit_strobe = 1'b1;
        end
        if (display_timer != 0) begin
          display_timer--;
          res.show_index = 1'b1;
          res.lit_count  = LIT_W'(cur_effect) + 1'b1;
        end
      end
      default: ;  // spare action codes leave everything alone
    endcase
    res.effect_index     = cur_effect;
    res.brightness_level = cur_brightness;
    res.chord_shift      = cur_chord;
    res.bass_shift       = cur_bass;
  endtask

  // One line per miss, and every miss is counted
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s: got %0d, want %0d",
                                result_no, name, got, want));
  endtask

  // Watch config writes and both item channels
  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst_n) begin
      ctl_ch         = CONTROL_CH_RST;
      chord_ch       = CHORD_CH_RST;
      bass_ch        = BASS_CH_RST;
      bright_cc      = BRIGHT_CC_RST;
      cur_effect     = '0;
      cur_brightness = BRIGHT_RST;
      cur_chord      = '0;
      cur_bass       = '0;
      save_timer     = '0;
      display_timer  = '0;
      predicted_settings_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CONTROL_CH: ctl_ch    = pwdata[3:0];
          REG_CHORD_CH:   chord_ch  = pwdata[3:0];
          REG_BASS_CH:    bass_ch   = pwdata[3:0];
          REG_BRIGHT_CC:  bright_cc = pwdata[6:0];
          default: ;
        endcase
      end
      // results first, so an item taken on this edge cannot match itself
      if (out_valid && !out_stall) begin
        got = out_data;
        if (predicted_settings_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing predicted", result_no));
        end else begin
          want = predicted_settings_q.pop_front();
          check_field("effect_index",     8'(got.effect_index),     8'(want.effect_index));
          check_field("brightness_level", got.brightness_level,     want.brightness_level);
          check_field("chord_shift",      got.chord_shift,          want.chord_shift);
          check_field("bass_shift",       got.bass_shift,           want.bass_shift);
          check_field("settings_changed", 8'(got.settings_changed), 8'(want.settings_changed));
          check_field("commit_strobe",    8'(got.commit_strobe),    8'(want.commit_strobe));
          check_field("show_index",       8'(got.show_index),       8'(want.show_index));
          check_field("lit_count",        8'(got.lit_count),        8'(want.lit_count));
        end
        result_no++;
      end
      if (in_valid && !in_stall) begin
        apply_midi_event(in_data, want);
        predicted_settings_q.push_back(want);
      end
    end
    pending = predicted_settings_q.size();
  end

endmodule

// ===== dv/midi_effect_settings_control_test.sv =====
// Top of the settings controller testbench: clock, reset, config writes, item
// stimulus with bursty sending and patterned result stalls, and the verdict.
// Depends on msc_pkg, midi_effect_settings_control and midi_settings_checker.
module midi_effect_settings_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msc_pkg::*;

  localparam int RUN_LIMIT = 200000;  // cycles

  // Action codes the block does not define
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  int pending, fail_count, cycle_count = 0;

  // Sender pacing and receiver hold-off control
  int   burst_left = 0;
  bit   no_gap = 1'b0;
  bit   hold_req = 1'b0;

  // Current register settings, used to aim the random items
  logic [3:0] ctl_channel, chord_channel, bass_channel;
  logic [6:0] bright_cc;

  midi_effect_settings_control u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  midi_settings_checker u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending, .fail_count
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result stalls: random segments of varying density, plus a long hold on request
  initial begin : rx_stall
    int seg_left, stall_pct, hold_left;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 250;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one item; entered and left at a falling edge, valid stays high
  task automatic offer(input in_item_t ev);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] ctl, input logic [3:0] chord,
                            input logic [3:0] bass, input logic [6:0] cc);
    drain();
    cfg_write(REG_CONTROL_CH, CFG_DATA_W'(ctl));
    cfg_write(REG_CHORD_CH,   CFG_DATA_W'(chord));
    cfg_write(REG_BASS_CH,    CFG_DATA_W'(bass));
    cfg_write(REG_BRIGHT_CC,  CFG_DATA_W'(cc));
    ctl_channel   = ctl;
    chord_channel = chord;
    bass_channel  = bass;
    bright_cc     = cc;
  endtask

  // Event with random stored values; restore uses its own
  function automatic in_item_t make_event(input logic [2:0] act, input logic [3:0] ch,
                                          input logic [6:0] key, input logic [6:0] val);
    in_item_t ev;
    ev.action            = act;
    ev.channel           = ch;
    ev.key               = key;
    ev.value             = val;
    ev.saved_effect      = 16'($urandom);
    ev.saved_brightness  = 16'($urandom);
    ev.saved_chord_shift = 16'($urandom);
    ev.saved_bass_shift  = 16'($urandom);
    return ev;
  endfunction

  function automatic in_item_t make_restore(input logic signed [15:0] eff,
                                            input logic signed [15:0] bright,
                                            input logic signed [15:0] chord,
                                            input logic signed [15:0] bass);
    in_item_t ev;
    ev = make_event(ACT_RESTORE, 4'($urandom), 7'($urandom), 7'($urandom));
    ev.saved_effect      = eff;
    ev.saved_brightness  = bright;
    ev.saved_chord_shift = chord;
    ev.saved_bass_shift  = bass;
    return ev;
  endfunction

  // Stored values: full range, near the clamp limits, or the extremes
  function automatic logic signed [15:0] rand_saved();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 600)) - 300);
      2: begin
        case ($urandom_range(0, 7))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd64;
          3: return 16'sd64;
          4: return 16'sd11;
          5: return 16'sd256;
          6: return 16'sd16;
          default: return -16'sd1;
        endcase
      end
      default: return 16'($urandom_range(0, 300));
    endcase
  endfunction

  // Mostly one of the configured channels
  function automatic logic [3:0] pick_channel();
    case ($urandom_range(0, 9))
      0, 1, 2: return ctl_channel;
      3, 4:    return chord_channel;
      5, 6:    return bass_channel;
      default: return 4'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_event();
    int pick;
    logic [6:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      return make_restore(rand_saved(), rand_saved(), rand_saved(), rand_saved());
    if (pick < 45)
      return make_event(ACT_NOTE_ON, pick_channel(), 7'($urandom), 7'($urandom));
    if (pick < 65) begin
      key = ($urandom_range(0, 9) < 6) ? bright_cc : 7'($urandom);
      return make_event(ACT_CTRL, 4'($urandom), key, 7'($urandom));
    end
    if (pick < 80)
      return make_event(ACT_PROGRAM, pick_channel(), 7'($urandom),
                        ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 15))
                                                    : 7'($urandom));
    return make_event(ACT_TICK, 4'($urandom), 7'($urandom), 7'($urandom));
  endfunction

  function automatic in_item_t noise_event();
    return make_event(3'($urandom), 4'($urandom), 7'($urandom), 7'($urandom));
  endfunction

  // Random scenes: armed countdowns, tick runs, mixed events and noise;
  // every scene is cut to what is left of the phase's item count
  task automatic run_phase(input int target);
    int sent, kind, len;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
        // arm both timers, then tick up to around the commit point
        offer(make_event(ACT_NOTE_ON, ctl_channel, 7'($urandom), 7'($urandom)));
        sent += 1;
        len = $urandom_range(195, 210);
        if (len > target - sent) len = target - sent;
        repeat (len) offer(make_event(ACT_TICK, 4'($urandom), 7'($urandom), 7'($urandom)));
        sent += len;
      end else if (kind == 1) begin
        len = $urandom_range(1, 40);
        if (len > target - sent) len = target - sent;
        repeat (len) offer(make_event(ACT_TICK, 4'($urandom), 7'($urandom), 7'($urandom)));
        sent += len;
      end else if (kind <= 9) begin
        len = $urandom_range(10, 30);
        if (len > target - sent) len = target - sent;
        repeat (len) offer(rand_event());
        sent += len;
      end else begin
        len = $urandom_range(3, 10);
        if (len > target - sent) len = target - sent;
        repeat (len) offer(noise_event());
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    ctl_channel   = CONTROL_CH_RST;
    chord_channel = CHORD_CH_RST;
    bass_channel  = BASS_CH_RST;
    bright_cc     = BRIGHT_CC_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset config (control 0, chord 4, bass 5, controller 91)
    offer(make_event(ACT_TICK, 4'd0, 7'd0, 7'd0));             // idle timers
    offer(make_restore(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767));
    offer(make_restore(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768));
    offer(make_restore(16'sd15, 16'sd11, -16'sd64, 16'sd64));
    offer(make_restore(16'sd0, 16'sd256, 16'sd63, -16'sd63));
    offer(make_restore(16'sd16, 16'sd12, -16'sd63, 16'sd63));  // effect clamps to top
    offer(make_event(ACT_NOTE_ON, 4'd0, 7'd0, 7'd0));          // wraps to zero
    offer(make_event(ACT_NOTE_ON, 4'd4, 7'd0, 7'd127));        // chord +64
    offer(make_event(ACT_NOTE_ON, 4'd5, 7'd127, 7'd0));        // bass -63
    offer(make_event(ACT_NOTE_ON, 4'd9, 7'd60, 7'd60));        // no channel matches
    offer(make_event(ACT_CTRL, 4'd3, 7'd91, 7'd127));
    offer(make_event(ACT_CTRL, 4'd15, 7'd91, 7'd0));
    offer(make_event(ACT_CTRL, 4'd0, 7'd90, 7'd50));           // other controller
    offer(make_event(ACT_PROGRAM, 4'd0, 7'd0, 7'd15));
    offer(make_event(ACT_PROGRAM, 4'd0, 7'd0, 7'd16));         // out of range
    offer(make_event(ACT_PROGRAM, 4'd7, 7'd0, 7'd3));          // wrong channel
    offer(make_event(ACT_PROGRAM, 4'd0, 7'd127, 7'd127));
    offer(make_event(ACT_TICK, 4'd15, 7'd127, 7'd127));        // shows index 15
    offer(make_event(ACT_NOTE_ON, 4'd0, 7'd127, 7'd127));      // wraps from 15
    offer(make_event(ACT_TICK, 4'd0, 7'd0, 7'd0));
    offer(make_event(ACT_SPARE_5, 4'd15, 7'd127, 7'd127));
    offer(make_event(ACT_SPARE_6, 4'd0, 7'd0, 7'd0));
    offer(make_event(ACT_SPARE_7, 4'd15, 7'd127, 7'd127));
    offer(make_event(ACT_CTRL, 4'd1, 7'd91, 7'd64));
    offer(make_event(ACT_PROGRAM, 4'd0, 7'd0, 7'd0));
    offer(make_event(ACT_TICK, 4'd0, 7'd0, 7'd0));

    // Back-pressure: receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    no_gap   = 1'b1;
    repeat (40) offer(rand_event());
    no_gap   = 1'b0;
    drain();
    run_phase(280);

    // Channels coincide, top controller number
    set_config(4'd15, 4'd15, 4'd15, 7'd127);
    run_phase(310);

    set_config(4'd0, 4'd0, 4'd0, 7'd0);
    run_phase(310);

    set_config(4'($urandom), 4'($urandom), 4'($urandom), 7'($urandom));
    run_phase(150);
    drain();  // pause mid-phase until everything is back
    run_phase(150);

    set_config(4'($urandom), 4'($urandom), 4'($urandom), 7'($urandom));
    run_phase(310);

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
